// ===== hdl/lfusr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LFU slot replacement unit.
package lfusr_pkg;

	localparam int unsigned VOTE_W         = 16;
	localparam int unsigned ARR_W          = 32;
	localparam int unsigned CFG_W          = 5;
	localparam int unsigned SLOT_IDX_OUT_W = 4;
	localparam int unsigned OCC_OUT_W      = 5;

	localparam logic [VOTE_W-1:0] VOTE_MAX   = '1;
	localparam logic [VOTE_W-1:0] VOTE_FIRST = VOTE_W'(1);
	localparam logic [ARR_W-1:0]  ARR_MAX    = '1;
	localparam logic [CFG_W-1:0]  CFG_RESET  = CFG_W'(16);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic found;
		logic victim_valid;
		logic free_valid;
	} scan_flags_t;

endpackage

// ===== hdl/lfusr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lfusr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/lfusr_scan.sv =====
`timescale 1ns / 1ps
// Slot scan: tracks hit, least-voted oldest victim and first free slot.
module lfusr_scan import lfusr_pkg::*; #(
	parameter int unsigned SLOT_COUNT = 16,
	parameter int unsigned ID_WIDTH   = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      ent_en,
	input  logic                      ent_valid,
	input  logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] ent_idx,
	input  logic [ID_WIDTH-1:0]       ent_cand,
	input  logic [VOTE_W-1:0]         ent_votes,
	input  logic [ARR_W-1:0]          ent_arrival,
	input  logic [ID_WIDTH-1:0]       id,
	output scan_flags_t               flags,
	output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] hit_idx,
	output logic [VOTE_W-1:0]         hit_votes,
	output logic [ARR_W-1:0]          hit_arrival,
	output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] victim_idx,
	output logic [ID_WIDTH-1:0]       victim_cand,
	output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] free_idx
);

	scan_flags_t                 flags_q;
	logic [VOTE_W+ARR_W-1:0]     victim_key_q;
	logic [VOTE_W+ARR_W-1:0]     ent_key;
	logic                        is_hit;
	logic                        is_lower;

	assign ent_key  = {ent_votes, ent_arrival};
	assign is_hit   = ent_en && ent_valid && (ent_cand == id) && !flags_q.found;
	assign is_lower = ent_en && ent_valid && (!flags_q.victim_valid || ent_key < victim_key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (start) begin
			flags_q <= '0;
		end else begin
			if (is_hit) begin
				flags_q.found <= 1'b1;
			end
			if (is_lower) begin
				flags_q.victim_valid <= 1'b1;
			end
			if (ent_en && !ent_valid) begin
				flags_q.free_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_hit) begin
			hit_idx     <= ent_idx;
			hit_votes   <= ent_votes;
			hit_arrival <= ent_arrival;
		end
		if (is_lower) begin
			victim_idx   <= ent_idx;
			victim_cand  <= ent_cand;
			victim_key_q <= ent_key;
		end
		if (ent_en && !ent_valid && !flags_q.free_valid) begin
			free_idx <= ent_idx;
		end
	end

	assign flags = flags_q;

endmodule

// ===== hdl/lfu_slot_replacement_unit.sv =====
`timescale 1ns / 1ps
// LFU slot replacement unit: top level with control sequencer and slot memory.
//
// One vote (candidate_id) is taken on the input channel when in_valid is high
// and in_stall is low. Each vote yields exactly one result on the output
// channel: hit, evicted_valid, evicted_id, slot_index and occupied_slots.
// After acceptance the vote passes through the scan, drain and commit states,
// and a new vote is taken only once the unit is back in idle. The slot memory
// is read one slot per cycle during the scan, and the scan unit folds in hit
// lookup, victim choice and first free slot; then the chosen slot is written
// back. One vote is in flight at a time; in_stall is high while a vote is
// scanned or committed.
// The result sits in an output register. While out_stall holds it, the next
// vote is accepted and scanned, and its commit waits until the register frees.
// slots_in_use is written through cfg_valid/cfg_ready (always ready); the user
// must write it only while no vote is pending, and the block does not enforce
// this. Reset clears the valid bits, occupancy, arrival counter and output
// valid, and sets slots_in_use to 16; slot contents need no clear.
module lfu_slot_replacement_unit import lfusr_pkg::*; #(
	parameter int unsigned SLOT_COUNT = 16,
	parameter int unsigned ID_WIDTH   = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [ID_WIDTH-1:0]       candidate_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      hit,
	output logic                      evicted_valid,
	output logic [ID_WIDTH-1:0]       evicted_id,
	output logic [SLOT_IDX_OUT_W-1:0] slot_index,
	output logic [OCC_OUT_W-1:0]      occupied_slots,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_W-1:0]          cfg_data
);

	localparam int unsigned IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned OCC_W   = $clog2(SLOT_COUNT + 1);
	localparam int unsigned CMP_W   = (OCC_W > CFG_W) ? OCC_W : CFG_W;
	localparam int unsigned ENTRY_W = ID_WIDTH + VOTE_W + ARR_W;

	state_t                  state_q;
	state_t                  state_next;
	logic [CFG_W-1:0]        cfg_q;
	logic [OCC_W-1:0]        occ_q;
	logic [ARR_W-1:0]        arr_q;
	logic [SLOT_COUNT-1:0]   valid_q;
	logic [IDX_W-1:0]        addr_q;
	logic [ID_WIDTH-1:0]     id_q;
	logic                    rd_pend_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic                    out_valid_q;

	logic                    accept;
	logic                    rd_en;
	logic                    commit_wait;
	logic                    commit;
	logic                    last_addr;
	logic [ENTRY_W-1:0]      rd_data;
	logic [ENTRY_W-1:0]      wr_data;

	scan_flags_t             flags;
	logic [IDX_W-1:0]        hit_idx;
	logic [VOTE_W-1:0]       hit_votes;
	logic [ARR_W-1:0]        hit_arrival;
	logic [IDX_W-1:0]        victim_idx;
	logic [ID_WIDTH-1:0]     victim_cand;
	logic [IDX_W-1:0]        free_idx;

	logic [CMP_W-1:0]        cfg_ext;
	logic [CMP_W-1:0]        limit;
	logic                    full;
	logic                    ev_valid;
	logic [IDX_W-1:0]        target;
	logic [VOTE_W-1:0]       votes_inc;
	logic [OCC_W-1:0]        occ_next;

	// sequencer
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_addr) state_next = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_next = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!out_valid_q || !out_stall) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		rd_en       = 1'b0;
		commit_wait = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_COMMIT: begin
				commit_wait = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign accept    = in_valid && !in_stall;
	assign commit    = commit_wait && (!out_valid_q || !out_stall);
	assign last_addr = (addr_q == IDX_W'(SLOT_COUNT - 1));
	assign cfg_ready = 1'b1;

	// slot memory: {candidate, votes, arrival}
	lfusr_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (commit),
		.wr_addr (target),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	lfusr_scan #(
		.SLOT_COUNT (SLOT_COUNT),
		.ID_WIDTH   (ID_WIDTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.ent_en      (rd_pend_s1),
		.ent_valid   (valid_q[rd_idx_s1]),
		.ent_idx     (rd_idx_s1),
		.ent_cand    (rd_data[ENTRY_W-1 -: ID_WIDTH]),
		.ent_votes   (rd_data[ARR_W +: VOTE_W]),
		.ent_arrival (rd_data[ARR_W-1:0]),
		.id          (id_q),
		.flags       (flags),
		.hit_idx     (hit_idx),
		.hit_votes   (hit_votes),
		.hit_arrival (hit_arrival),
		.victim_idx  (victim_idx),
		.victim_cand (victim_cand),
		.free_idx    (free_idx)
	);

	// effective limit clamps to 1..SLOT_COUNT
	assign cfg_ext = CMP_W'(cfg_q);
	always_comb begin
		if (cfg_ext == '0) begin
			limit = CMP_W'(1);
		end else if (cfg_ext > CMP_W'(SLOT_COUNT)) begin
			limit = CMP_W'(SLOT_COUNT);
		end else begin
			limit = cfg_ext;
		end
	end

	assign full      = CMP_W'(occ_q) >= limit;
	assign ev_valid  = !flags.found && full && flags.victim_valid;
	assign votes_inc = (hit_votes == VOTE_MAX) ? hit_votes : hit_votes + VOTE_W'(1);
	assign occ_next  = (!flags.found && !ev_valid) ? occ_q + OCC_W'(1) : occ_q;

	always_comb begin
		if (flags.found) begin
			target  = hit_idx;
			wr_data = {id_q, votes_inc, hit_arrival};
		end else begin
			target  = full ? victim_idx : free_idx;
			wr_data = {id_q, VOTE_FIRST, arr_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_RESET;
			occ_q       <= '0;
			arr_q       <= '0;
			valid_q     <= '0;
			addr_q      <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_next;
			rd_pend_s1 <= rd_en;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (accept) begin
				addr_q <= '0;
			end else if (rd_en && !last_addr) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			if (commit) begin
				occ_q <= occ_next;
				if (arr_q != ARR_MAX) arr_q <= arr_q + ARR_W'(1);
				if (!flags.found) valid_q[target] <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (accept) begin
			id_q <= candidate_id;
		end
		if (commit) begin
			hit            <= flags.found;
			evicted_valid  <= ev_valid;
			evicted_id     <= ev_valid ? victim_cand : '0;
			slot_index     <= SLOT_IDX_OUT_W'(target);
			occupied_slots <= OCC_OUT_W'(occ_next);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== tb/sv/lfu_slot_replacement_unit_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the LFU slot replacement unit: tracks votes, predicts each result and compares.
module lfu_slot_replacement_unit_checker import lfusr_pkg::*; #(
	parameter int unsigned SLOT_COUNT = 16,
	parameter int unsigned ID_WIDTH   = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [ID_WIDTH-1:0]       candidate_id,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic                      hit,
	input  logic                      evicted_valid,
	input  logic [ID_WIDTH-1:0]       evicted_id,
	input  logic [SLOT_IDX_OUT_W-1:0] slot_index,
	input  logic [OCC_OUT_W-1:0]      occupied_slots,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_W-1:0]          cfg_data,
	output int                        mismatches,
	output int                        pending
);

	typedef struct packed {
		logic                      hit;
		logic                      evicted_valid;
		logic [ID_WIDTH-1:0]       evicted_id;
		logic [SLOT_IDX_OUT_W-1:0] slot_index;
		logic [OCC_OUT_W-1:0]      occupied_slots;
	} vote_result_t;

	logic                tbl_valid   [SLOT_COUNT];
	logic [ID_WIDTH-1:0] tbl_id      [SLOT_COUNT];
	logic [VOTE_W-1:0]   tbl_votes   [SLOT_COUNT];
	logic [ARR_W-1:0]    tbl_arrival [SLOT_COUNT];
	logic [ARR_W-1:0]    arrival_next;
	int unsigned         occ;
	logic [CFG_W-1:0]    slot_limit;
	vote_result_t        vote_results_q [$];
	vote_result_t        oldest;
	int                  err_total;

	function automatic int unsigned usable_slots();
		int unsigned lim;
		lim = slot_limit;
		if (lim < 1) lim = 1;
		if (lim > SLOT_COUNT) lim = SLOT_COUNT;
		return lim;
	endfunction

	function automatic vote_result_t cast_vote(logic [ID_WIDTH-1:0] id);
		vote_result_t r;
		int           target;
		bit           found;
		bit           have;
		r      = '0;
		target = 0;
		found  = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!found && tbl_valid[i] && tbl_id[i] == id) begin
				target = i;
				found  = 1'b1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			if (tbl_votes[target] != VOTE_MAX) tbl_votes[target]++;
		end else begin
			if (occ >= usable_slots()) begin
				// fewest votes first, then oldest arrival, then lowest index
				have = 1'b0;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (tbl_valid[i] && (!have || tbl_votes[i] < tbl_votes[target] ||
							(tbl_votes[i] == tbl_votes[target] &&
							tbl_arrival[i] < tbl_arrival[target]))) begin
						target = i;
						have   = 1'b1;
					end
				end
				if (have) begin
					r.evicted_valid   = 1'b1;
					r.evicted_id      = tbl_id[target];
					tbl_valid[target] = 1'b0;
					occ--;
				end
			end else begin
				for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
					if (!tbl_valid[i]) target = i;
				end
			end
			tbl_valid[target]   = 1'b1;
			tbl_id[target]      = id;
			tbl_votes[target]   = VOTE_FIRST;
			tbl_arrival[target] = arrival_next;
			occ++;
		end
		if (arrival_next != ARR_MAX) arrival_next++;
		r.slot_index     = SLOT_IDX_OUT_W'(target);
		r.occupied_slots = OCC_OUT_W'(occ);
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			err_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				tbl_valid[i]   = 1'b0;
				tbl_id[i]      = '0;
				tbl_votes[i]   = '0;
				tbl_arrival[i] = '0;
			end
			arrival_next = '0;
			occ          = 0;
			slot_limit   = CFG_RESET;
			err_total    = 0;
			vote_results_q.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (vote_results_q.size() == 0) begin
					$display("%0t: result with no vote waiting: hit %0d evicted %0d/%0d slot %0d occ %0d",
						$time, hit, evicted_valid, evicted_id, slot_index, occupied_slots);
					err_total++;
				end else begin
					oldest = vote_results_q.pop_front();
					check_field("hit", oldest.hit, hit);
					check_field("evicted_valid", oldest.evicted_valid, evicted_valid);
					check_field("evicted_id", oldest.evicted_id, evicted_id);
					check_field("slot_index", oldest.slot_index, slot_index);
					check_field("occupied_slots", oldest.occupied_slots, occupied_slots);
				end
			end
			if (cfg_valid && cfg_ready) slot_limit = cfg_data;
			if (in_valid && !in_stall) vote_results_q.push_back(cast_vote(candidate_id));
			mismatches <= err_total;
			pending    <= vote_results_q.size();
		end
	end

endmodule

// ===== tb/sv/lfu_slot_replacement_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the LFU slot replacement unit: clock, reset, vote stimulus and verdict.
module lfu_slot_replacement_unit_tb;
	import lfusr_pkg::*;

	localparam int unsigned SLOT_COUNT = 16;
	localparam int unsigned ID_WIDTH   = 7;
	localparam int          CLK_HALF   = 10;
	localparam int          IDLE_LIMIT = 2000;
	localparam int          LONG_HOLD  = 200;
	localparam int          SETTLE     = 24;
	localparam int          PHASES     = 7;
	localparam int          PHASE_LEN  = 64;

	logic                      clk            = 1'b0;
	logic                      arst_n         = 1'b0;
	logic                      in_valid       = 1'b0;
	logic                      in_stall;
	logic [ID_WIDTH-1:0]       candidate_id   = '0;
	logic                      out_valid;
	logic                      out_stall      = 1'b0;
	logic                      hit;
	logic                      evicted_valid;
	logic [ID_WIDTH-1:0]       evicted_id;
	logic [SLOT_IDX_OUT_W-1:0] slot_index;
	logic [OCC_OUT_W-1:0]      occupied_slots;
	logic                      cfg_valid      = 1'b0;
	logic                      cfg_ready;
	logic [CFG_W-1:0]          cfg_data       = '0;

	int mismatches;
	int pending;
	int max_gap       = 8;
	int max_hold      = 8;
	bit long_hold_req = 1'b0;
	int votes_sent    = 0;
	int limits_set    = 0;
	int idle_cycles   = 0;

	always #(CLK_HALF) clk = ~clk;

	lfu_slot_replacement_unit #(
		.SLOT_COUNT(SLOT_COUNT),
		.ID_WIDTH  (ID_WIDTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.candidate_id  (candidate_id),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_id    (evicted_id),
		.slot_index    (slot_index),
		.occupied_slots(occupied_slots),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	lfu_slot_replacement_unit_checker #(
		.SLOT_COUNT(SLOT_COUNT),
		.ID_WIDTH  (ID_WIDTH)
	) vote_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.candidate_id  (candidate_id),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_id    (evicted_id),
		.slot_index    (slot_index),
		.occupied_slots(occupied_slots),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	task automatic send_vote(input logic [ID_WIDTH-1:0] id);
		int gap;
		gap = $urandom_range(max_gap, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		candidate_id <= id;
		do @(posedge clk); while (in_stall);
		votes_sent++;
	endtask

	// pending is registered, so the wait loop samples it only after advancing the clock
	task automatic settle_all();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] value);
		settle_all();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limits_set++;
	endtask

	initial begin : receiver
		int hold;
		forever begin
			hold          = long_hold_req ? LONG_HOLD : $urandom_range(max_hold, 0);
			long_hold_req = 1'b0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, idle_cycles);
			$display("lfu_slot_replacement_unit_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0]    phase_limit [PHASES];
		logic [CFG_W-1:0]    lim;
		logic [ID_WIDTH-1:0] pool_base;
		logic [ID_WIDTH-1:0] id;
		int                  eff;
		int                  pool_span;

		phase_limit = '{5'd1, 5'd16, 5'd4, 5'd31, 5'd8, 5'd0, 5'd0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit: id extremes, hits, partial fill
		send_vote(7'd0);
		send_vote(7'd127);
		send_vote(7'd0);
		send_vote(7'd85);
		send_vote(7'd42);
		send_vote(7'd127);
		// limit dropped below occupancy; hit on a slot past the limit
		write_limit(5'd2);
		send_vote(7'd1);
		send_vote(7'd42);
		send_vote(7'd2);
		// zero acts as one
		write_limit(5'd0);
		send_vote(7'd5);
		send_vote(7'd5);
		send_vote(7'd6);
		// above slot count acts as full table, then evict
		write_limit(5'd31);
		for (int i = 0; i < 13; i++) send_vote(ID_WIDTH'(96 + i));

		for (int p = 0; p < PHASES; p++) begin
			lim = (p == PHASES - 1) ? CFG_W'($urandom_range(31, 0)) : phase_limit[p];
			write_limit(lim);
			eff           = (lim == 0) ? 1 : (lim > SLOT_COUNT) ? SLOT_COUNT : lim;
			pool_span     = eff + 2;
			pool_base     = ID_WIDTH'($urandom_range(127, 0));
			max_gap       = (p == 2) ? 0 : 8;
			max_hold      = (p == 2 || p == 5) ? 0 : 8;
			long_hold_req = (p == 3);
			for (int i = 0; i < PHASE_LEN; i++) begin
				if ($urandom_range(9, 0) < 2) id = ID_WIDTH'($urandom_range(127, 0));
				else id = ID_WIDTH'(pool_base + $urandom_range(pool_span, 0));
				send_vote(id);
				if (p == 4 && i == PHASE_LEN / 2) settle_all();
			end
		end

		settle_all();
		$display("covered %0d votes over %0d slots_in_use writes (0, 1, 2, 4, 8, 16, 31, random)",
			votes_sent, limits_set);
		$display("with random sender gaps and output stalls, a no-idle stretch and a long output hold");
		if (mismatches == 0 && pending == 0) begin
			$display("lfu_slot_replacement_unit_tb: clean");
		end else begin
			$display("lfu_slot_replacement_unit_tb: errors");
		end
		$finish;
	end

endmodule
